>>> rtl/srpg_pkg.sv
// ----------------------------------------------------------------------------
// srpg_pkg
// Shared widths, register indexes, reset values and the controller/datapath
// command and status types of the linear ramp step pulse generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srpg_pkg;

  localparam int BASE_W     = 20;  // half-period registers
  localparam int CNT_W      = 16;  // step count field
  localparam int MULT_W     = 5;   // microstep multiplier register
  localparam int MM_W       = 9;   // mult * mult, up to 256
  localparam int DEN_W      = 24;  // mult * mult * count, below 2^24
  localparam int PULSE_W    = 20;  // count * mult, below 2^20
  localparam int AXIS_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MULT  = 2'd2;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd3;

  localparam logic [BASE_W-1:0] RST_START = 20'd1000;
  localparam logic [BASE_W-1:0] RST_MIN   = 20'd100;
  localparam logic [MULT_W-1:0] RST_MULT  = 5'd1;
  localparam logic [MULT_W-1:0] MULT_MIN  = 5'd1;
  localparam logic [MULT_W-1:0] MULT_MAX  = 5'd16;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // input word taken this cycle
    logic sel_slope;  // divider operands: slope (1) or base half-period (0)
    logic base_cap;   // base quotient ready
    logic load;       // slope quotient ready, arm the segment
  } srpg_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic launch;     // current input word starts a segment needing the divider
    logic out_stall;  // result register full and not being drained
  } srpg_sts_t;

endpackage

`default_nettype wire

>>> rtl/srpg_div.sv
// ----------------------------------------------------------------------------
// srpg_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srpg_div #(
  parameter int NUM_W = 36,
  parameter int DEN_W = 24
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic      [NUM_W-1:0] quo_o
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [CW-1:0]    cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign rem_sh = {rem_q, quo_q[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den_q};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_comb begin
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    done_d = 1'b0;
    if (start_i) begin
      cnt_d = CW'(NUM_W);
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - CW'(1);
      quo_d  = {quo_q[NUM_W-2:0], ge};
      rem_d  = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      done_d = (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

>>> rtl/srpg_ctrl.sv
// ----------------------------------------------------------------------------
// srpg_ctrl
// Sequencer: takes words, runs the base and slope divisions for a start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srpg_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_valid_i,
  input  wire srpg_pkg::srpg_sts_t sts_i,
  input  wire logic                div_done_i,
  output logic                     s_ready_o,
  output logic                     div_start_o,
  output srpg_pkg::srpg_cmd_t      cmd_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_BASE  = 2'd1;
  localparam logic [1:0] ST_SLOPE = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign s_ready_o = (state_q == ST_IDLE) && !sts_i.out_stall;
  assign accept    = s_valid_i && s_ready_o;

  always_comb begin
    state_d     = state_q;
    div_start_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && sts_i.launch) begin
          div_start_o = 1'b1;
          state_d     = ST_BASE;
        end
      end
      ST_BASE: begin
        if (div_done_i) begin
          div_start_o = 1'b1;
          state_d     = ST_SLOPE;
        end
      end
      ST_SLOPE: begin
        if (div_done_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o.accept    = accept;
    cmd_o.sel_slope = (state_q == ST_BASE);
    cmd_o.base_cap  = (state_q == ST_BASE) && div_done_i;
    cmd_o.load      = (state_q == ST_SLOPE) && div_done_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/srpg_dp.sv
// ----------------------------------------------------------------------------
// srpg_dp
// Datapath: config registers, segment state, tick countdown, period ramp
// and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srpg_dp #(
  parameter int FRAC_BITS   = 16,
  parameter int PERIOD_BITS = 20
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire srpg_pkg::srpg_cmd_t               cmd_i,
  output srpg_pkg::srpg_sts_t                    sts_o,
  // input word
  input  wire logic                              op_i,
  input  wire logic                              ramp_down_i,
  input  wire logic                              direction_i,
  input  wire logic [srpg_pkg::AXIS_W-1:0]       axis_i,
  input  wire logic [srpg_pkg::CNT_W-1:0]        step_count_i,
  // config
  input  wire logic                              cfg_we_i,
  input  wire logic [srpg_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [srpg_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // divider
  output logic [srpg_pkg::BASE_W+FRAC_BITS-1:0]  div_num_o,
  output logic [srpg_pkg::DEN_W-1:0]             div_den_o,
  input  wire logic [srpg_pkg::BASE_W+FRAC_BITS-1:0] div_quo_i,
  // result word
  input  wire logic                              m_ready_i,
  output logic                                   m_valid_o,
  output logic                                   step_level_o,
  output logic                                   dir_level_o,
  output logic [srpg_pkg::AXIS_W-1:0]            active_axis_o,
  output logic                                   busy_res_o,
  output logic                                   segment_done_o,
  output logic [srpg_pkg::BASE_W-1:0]            current_half_period_o
);

  localparam int ACC_W = srpg_pkg::BASE_W + FRAC_BITS;
  localparam int PW    = (PERIOD_BITS > srpg_pkg::BASE_W) ? PERIOD_BITS : srpg_pkg::BASE_W;
  localparam int SUM_W = PW + 2;
  localparam logic [63:0]   PMAX64 = (64'd1 << PERIOD_BITS) - 64'd1;
  localparam logic [PW-1:0] PMAX   = PMAX64[PW-1:0];

  // config
  logic [srpg_pkg::BASE_W-1:0] start_q, min_q;
  logic [srpg_pkg::MULT_W-1:0] mult_q;

  // segment state
  logic                         running_q, running_d;
  logic                         down_q, down_d;
  logic [srpg_pkg::AXIS_W-1:0]  axis_q, axis_d;
  logic                         dir_q, dir_d;
  logic                         pin_q, pin_d;
  logic [PW-1:0]                ticks_q, ticks_d;
  logic [srpg_pkg::PULSE_W-1:0] pulses_q, pulses_d;
  logic [PW-1:0]                period_q, period_d;
  logic [ACC_W-1:0]             acc_q, acc_d;
  logic [ACC_W-1:0]             slope_q, slope_d;

  // start operands
  logic [srpg_pkg::BASE_W-1:0]  base_q;
  logic [srpg_pkg::MULT_W-1:0]  m_q;
  logic [srpg_pkg::MM_W-1:0]    mm_q;
  logic [srpg_pkg::CNT_W-1:0]   count_q;
  logic [srpg_pkg::DEN_W-1:0]   den_q;

  // result register
  logic                         ovalid_q;
  logic                         ostep_q, odir_q, obusy_q, odone_q;
  logic [srpg_pkg::AXIS_W-1:0]  oaxis_q;
  logic [srpg_pkg::BASE_W-1:0]  operiod_q;

  logic [srpg_pkg::MULT_W-1:0]  mclamp;
  logic                         start_ok, launch, capture, done_c;
  logic [srpg_pkg::BASE_W-1:0]  off, diff_cfg;
  logic [SUM_W-1:0]             sum;
  logic [PW-1:0]                next_p, base_sat, ticks_dec;
  logic [srpg_pkg::PULSE_W-1:0] pulses_dec;

  function automatic logic [PW-1:0] half_ticks(input logic [PW-1:0] p);
    return (p == '0) ? PW'(1) : p;
  endfunction

  always_comb begin
    if (mult_q == '0) begin
      mclamp = srpg_pkg::MULT_MIN;
    end else if (mult_q > srpg_pkg::MULT_MAX) begin
      mclamp = srpg_pkg::MULT_MAX;
    end else begin
      mclamp = mult_q;
    end
  end

  assign start_ok = (op_i == srpg_pkg::OP_START) && !running_q
                    && (axis_i != srpg_pkg::AXIS_NONE);
  assign launch   = start_ok && (step_count_i != '0);

  assign sts_o.launch    = launch;
  assign sts_o.out_stall = ovalid_q && !m_ready_i;

  // base divide starts on the accepting edge, so it reads the live input
  assign diff_cfg = start_q - min_q;
  always_comb begin
    if (cmd_i.sel_slope) begin
      div_num_o = (start_q >= min_q) ? {diff_cfg, {FRAC_BITS{1'b0}}} : '0;
      div_den_o = den_q;
    end else begin
      div_num_o = ACC_W'(ramp_down_i ? min_q : start_q);
      div_den_o = srpg_pkg::DEN_W'(mclamp);
    end
  end

  // ramp step: base -/+ integer part of the accumulated slope
  assign off      = acc_q[ACC_W-1:FRAC_BITS];
  assign sum      = SUM_W'(base_q) + SUM_W'(off);
  assign base_sat = (PW'(base_q) > PMAX) ? PMAX : PW'(base_q);
  always_comb begin
    if (down_q) begin
      next_p = (sum > SUM_W'(PMAX)) ? PMAX : sum[PW-1:0];
    end else begin
      next_p = (off >= base_q) ? '0 : PW'(base_q - off);
    end
  end

  assign ticks_dec  = ticks_q - PW'(1);
  assign pulses_dec = pulses_q - srpg_pkg::PULSE_W'(1);

  always_comb begin
    running_d = running_q;
    down_d    = down_q;
    axis_d    = axis_q;
    dir_d     = dir_q;
    pin_d     = pin_q;
    ticks_d   = ticks_q;
    pulses_d  = pulses_q;
    period_d  = period_q;
    acc_d     = acc_q;
    slope_d   = slope_q;
    done_c    = 1'b0;
    if (cmd_i.accept) begin
      if (op_i == srpg_pkg::OP_START) begin
        if (start_ok) begin
          axis_d = axis_i;
          dir_d  = direction_i;
          down_d = ramp_down_i;
          if (step_count_i == '0) begin
            pin_d  = 1'b0;
            done_c = 1'b1;
          end
        end
      end else if (running_q) begin
        ticks_d = ticks_dec;
        if (ticks_dec == '0) begin
          if (pin_q) begin
            pin_d   = 1'b0;
            ticks_d = half_ticks(period_q);
          end else begin
            pulses_d = pulses_dec;
            if (pulses_dec == '0) begin
              running_d = 1'b0;
              done_c    = 1'b1;
            end else begin
              period_d = next_p;
              acc_d    = acc_q + slope_q;
              pin_d    = 1'b1;
              ticks_d  = half_ticks(next_p);
            end
          end
        end
      end
    end
    if (cmd_i.load) begin
      slope_d   = div_quo_i;
      acc_d     = '0;
      period_d  = base_sat;
      pulses_d  = srpg_pkg::PULSE_W'(count_q) * srpg_pkg::PULSE_W'(m_q);
      pin_d     = 1'b1;
      ticks_d   = half_ticks(base_sat);
      running_d = 1'b1;
    end
  end

  assign capture = (cmd_i.accept && !launch) || cmd_i.load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q   <= srpg_pkg::RST_START;
      min_q     <= srpg_pkg::RST_MIN;
      mult_q    <= srpg_pkg::RST_MULT;
      running_q <= 1'b0;
      down_q    <= 1'b0;
      axis_q    <= '0;
      dir_q     <= 1'b0;
      pin_q     <= 1'b0;
      ticks_q   <= '0;
      pulses_q  <= '0;
      period_q  <= '0;
      acc_q     <= '0;
      slope_q   <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          srpg_pkg::CFG_START: start_q <= cfg_data_i;
          srpg_pkg::CFG_MIN:   min_q   <= cfg_data_i;
          srpg_pkg::CFG_MULT:  mult_q  <= cfg_data_i[srpg_pkg::MULT_W-1:0];
          default: ;
        endcase
      end
      running_q <= running_d;
      down_q    <= down_d;
      axis_q    <= axis_d;
      dir_q     <= dir_d;
      pin_q     <= pin_d;
      ticks_q   <= ticks_d;
      pulses_q  <= pulses_d;
      period_q  <= period_d;
      acc_q     <= acc_d;
      slope_q   <= slope_d;
      if (capture) begin
        ovalid_q <= 1'b1;
      end else if (m_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && launch) begin
      m_q     <= mclamp;
      mm_q    <= srpg_pkg::MM_W'(mclamp) * srpg_pkg::MM_W'(mclamp);
      count_q <= step_count_i;
    end
    den_q <= srpg_pkg::DEN_W'(mm_q) * srpg_pkg::DEN_W'(count_q);
    if (cmd_i.base_cap) begin
      base_q <= div_quo_i[srpg_pkg::BASE_W-1:0];
    end
    if (capture) begin
      ostep_q   <= running_d && pin_d;
      odir_q    <= !dir_d;
      oaxis_q   <= axis_d;
      obusy_q   <= running_d;
      odone_q   <= done_c;
      operiod_q <= period_d[srpg_pkg::BASE_W-1:0];
    end
  end

  assign m_valid_o             = ovalid_q;
  assign step_level_o          = ostep_q;
  assign dir_level_o           = odir_q;
  assign active_axis_o         = oaxis_q;
  assign busy_res_o            = obusy_q;
  assign segment_done_o        = odone_q;
  assign current_half_period_o = operiod_q;

endmodule

`default_nettype wire

>>> rtl/stepper_linear_ramp_pulse_generator.sv
// ----------------------------------------------------------------------------
// stepper_linear_ramp_pulse_generator
// Step pulse generator with a linear half-period ramp per segment.
//
//  channel   dir  handshake                  contents
//  s_axis    in   tvalid/tready              tick or start command
//  m_axis    out  tvalid/tready              pin levels and status, one per word
//  cfg       in   cfg_we_i                   start/min half-period, multiplier
//
// Tick words are registered directly and stream back to back unless stalled.
// A start word that arms a segment runs two divisions through the shared
// restoring divider (base half-period, then slope), one bit per cycle:
// its result leaves after the slope division, with input held off meanwhile.
// The result register is the stall point: input waits while it is full and not drained.
// Reset clears the segment state and loads the config defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stepper_linear_ramp_pulse_generator #(
  parameter int FRAC_BITS   = 16,
  parameter int PERIOD_BITS = 20
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input word
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // ramp_down, direction, axis[1:0], step_count[15:0]
  input  wire logic        s_axis_tuser,  // operation
  // result word
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // step_level, dir_level, active_axis[1:0],
                                          // busy_res, current_half_period[19:0]
  output logic             m_axis_tlast,  // segment_done
  // config
  input  wire logic                              cfg_we_i,
  input  wire logic [srpg_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [srpg_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int ACC_W = srpg_pkg::BASE_W + FRAC_BITS;

  srpg_pkg::srpg_cmd_t          cmd;
  srpg_pkg::srpg_sts_t          sts;
  logic                         div_start, div_done;
  logic [ACC_W-1:0]             div_num, div_quo;
  logic [srpg_pkg::DEN_W-1:0]   div_den;
  logic                         step_level, dir_level, busy_res;
  logic [srpg_pkg::AXIS_W-1:0]  active_axis;
  logic [srpg_pkg::BASE_W-1:0]  cur_period;

  srpg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .sts_i       (sts),
    .div_done_i  (div_done),
    .s_ready_o   (s_axis_tready),
    .div_start_o (div_start),
    .cmd_o       (cmd)
  );

  srpg_div #(
    .NUM_W (ACC_W),
    .DEN_W (srpg_pkg::DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  srpg_dp #(
    .FRAC_BITS   (FRAC_BITS),
    .PERIOD_BITS (PERIOD_BITS)
  ) u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .op_i                  (s_axis_tuser),
    .ramp_down_i           (s_axis_tdata[0]),
    .direction_i           (s_axis_tdata[1]),
    .axis_i                (s_axis_tdata[3:2]),
    .step_count_i          (s_axis_tdata[19:4]),
    .cfg_we_i              (cfg_we_i),
    .cfg_idx_i             (cfg_idx_i),
    .cfg_data_i            (cfg_data_i),
    .div_num_o             (div_num),
    .div_den_o             (div_den),
    .div_quo_i             (div_quo),
    .m_ready_i             (m_axis_tready),
    .m_valid_o             (m_axis_tvalid),
    .step_level_o          (step_level),
    .dir_level_o           (dir_level),
    .active_axis_o         (active_axis),
    .busy_res_o            (busy_res),
    .segment_done_o        (m_axis_tlast),
    .current_half_period_o (cur_period)
  );

  assign m_axis_tdata = {7'd0, cur_period, busy_res, active_axis, dir_level, step_level};

`ifndef SYNTH
  // segment arm must never overwrite a pending result
  a_load_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> !m_axis_tvalid)
    else $error("segment armed while result register full");

  // armed segment reports busy in the next result
  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> (m_axis_tvalid && m_axis_tdata[4] && !m_axis_tlast))
    else $error("armed segment result not busy");

  // no input taken while a division runs
  a_div_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> !s_axis_tready)
    else $error("input ready during division");
`endif

endmodule

`default_nettype wire
